// ----- rtl/lfbd_pkg.sv -----
// ----------------------------------------------------------------------------
// lfbd_pkg
// Types and constants shared by the link frame bit deinterleaver modules.
// ----------------------------------------------------------------------------
package lfbd_pkg;

    localparam int CHANNELS    = 64;
    localparam int FRAME_BITS  = 192;
    localparam int WORD_BITS   = 16;
    localparam int FRAME_KINDS = 3;
    localparam int WORDS       = (FRAME_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ROWS        = FRAME_KINDS * WORDS;
    localparam int ROW_W       = CHANNELS * WORD_BITS;
    localparam int ROW_AW      = $clog2(ROWS);
    localparam int BC_W        = $clog2(FRAME_BITS + 1);
    localparam int IBIT_W      = $clog2(WORD_BITS);

    localparam logic [63:0] RST_BEGIN_A = 64'h5003000200010000;
    localparam logic [63:0] RST_BEGIN_B = 64'h5007000600050004;
    localparam logic [63:0] RST_BEGIN_C = 64'h5011001000090008;
    localparam logic [63:0] RST_END     = 64'ha000000000000000;

    localparam logic [1:0] REG_BEGIN_A = 2'd0;
    localparam logic [1:0] REG_BEGIN_B = 2'd1;
    localparam logic [1:0] REG_BEGIN_C = 2'd2;
    localparam logic [1:0] REG_END     = 2'd3;

    typedef enum logic [2:0] {
        ST_IGNORED   = 3'd0,
        ST_BEGUN     = 3'd1,
        ST_STORED    = 3'd2,
        ST_DONE      = 3'd3,
        ST_ABORT_BEG = 3'd4,
        ST_ABORT     = 3'd5,
        ST_READ      = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t             op;
        status_t             status;
        logic [1:0]          kind;
        logic [ROW_AW-1:0]   row;
        logic [IBIT_W-1:0]   ibit;
        logic                first;
        logic [CHANNELS-1:0] word;
        logic [5:0]          channel;
        logic                rd_ok;
    } op_t;

endpackage

// ----- rtl/lfbd_front.sv -----
// ----------------------------------------------------------------------------
// lfbd_front
// Accepts requests, matches patterns, tracks the frame phase and issues
// operations for the store.
// ----------------------------------------------------------------------------
module lfbd_front
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic                     req_type,
    input  logic [63:0]              link_word,
    input  logic [1:0]               read_type,
    input  logic [5:0]               read_channel,
    input  logic [3:0]               read_word,
    input  logic                     wr_en,
    input  logic [1:0]               wr_index,
    input  logic [63:0]              wr_data,
    output lfbd_pkg::op_t            op
);

    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_DATA = 3'b010,
        PH_ENDW = 3'b100
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic [1:0]                  kind_reg, kind_next;
    logic [lfbd_pkg::BC_W-1:0]   bc_reg, bc_next;
    logic [63:0]                 pat_a_reg, pat_b_reg, pat_c_reg, pat_e_reg;

    logic                        hit_a, hit_b, hit_c, is_begin, is_end, rd_ok;
    logic [1:0]                  bkind;
    logic [lfbd_pkg::BC_W-1:0]   bc_inc;
    logic [3:0]                  iword;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_a_reg <= lfbd_pkg::RST_BEGIN_A;
            pat_b_reg <= lfbd_pkg::RST_BEGIN_B;
            pat_c_reg <= lfbd_pkg::RST_BEGIN_C;
            pat_e_reg <= lfbd_pkg::RST_END;
        end
        else if (wr_en)
        begin
            case (wr_index)
                lfbd_pkg::REG_BEGIN_A: pat_a_reg <= wr_data;
                lfbd_pkg::REG_BEGIN_B: pat_b_reg <= wr_data;
                lfbd_pkg::REG_BEGIN_C: pat_c_reg <= wr_data;
                lfbd_pkg::REG_END:     pat_e_reg <= wr_data;
                default:               pat_e_reg <= pat_e_reg;
            endcase
        end
    end

    always_comb
    begin
        hit_a    = (link_word == pat_a_reg);
        hit_b    = (link_word == pat_b_reg);
        hit_c    = (link_word == pat_c_reg);
        is_begin = hit_a || hit_b || hit_c;
        bkind    = hit_a ? 2'd0 : (hit_b ? 2'd1 : 2'd2);
        is_end   = !is_begin && (link_word == pat_e_reg);
        bc_inc   = bc_reg + 1'b1;
        iword    = 4'(lfbd_pkg::WORDS - 1) - 4'(bc_reg / lfbd_pkg::WORD_BITS);
        rd_ok    = (read_type < 2'(lfbd_pkg::FRAME_KINDS))
                   && (read_word < 4'(lfbd_pkg::WORDS));

        phase_next = phase_reg;
        kind_next  = kind_reg;
        bc_next    = bc_reg;

        op         = '0;
        op.op      = lfbd_pkg::OP_NONE;
        op.status  = lfbd_pkg::ST_IGNORED;
        op.word    = link_word[lfbd_pkg::CHANNELS-1:0];
        op.channel = read_channel;
        op.ibit    = lfbd_pkg::IBIT_W'(lfbd_pkg::WORD_BITS - 1)
                     - lfbd_pkg::IBIT_W'(bc_reg % lfbd_pkg::WORD_BITS);
        op.first   = (bc_reg % lfbd_pkg::WORD_BITS) == 0;

        if (req_type)
        begin
            op.op     = lfbd_pkg::OP_READ;
            op.status = lfbd_pkg::ST_READ;
            op.rd_ok  = rd_ok;
            op.row    = rd_ok ? lfbd_pkg::ROW_AW'(read_type) * lfbd_pkg::ROW_AW'(lfbd_pkg::WORDS)
                                + lfbd_pkg::ROW_AW'(read_word) : '0;
        end
        else if (is_begin)
        begin
            op.op      = lfbd_pkg::OP_CLEAR;
            op.status  = (phase_reg == PH_HUNT) ? lfbd_pkg::ST_BEGUN : lfbd_pkg::ST_ABORT_BEG;
            op.row     = lfbd_pkg::ROW_AW'(bkind) * lfbd_pkg::ROW_AW'(lfbd_pkg::WORDS);
            kind_next  = bkind;
            bc_next    = '0;
            phase_next = PH_DATA;
        end
        else
        begin
            case (phase_reg)
                PH_DATA:
                begin
                    if (is_end)
                    begin
                        op.status  = lfbd_pkg::ST_ABORT;
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        op.op     = lfbd_pkg::OP_WRITE;
                        op.status = lfbd_pkg::ST_STORED;
                        op.row    = lfbd_pkg::ROW_AW'(kind_reg) * lfbd_pkg::ROW_AW'(lfbd_pkg::WORDS)
                                    + lfbd_pkg::ROW_AW'(iword);
                        bc_next   = bc_inc;
                        if (bc_inc >= lfbd_pkg::BC_W'(lfbd_pkg::FRAME_BITS))
                        begin
                            phase_next = PH_ENDW;
                        end
                    end
                end
                PH_ENDW:
                begin
                    op.status  = is_end ? lfbd_pkg::ST_DONE : lfbd_pkg::ST_ABORT;
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    op.status = lfbd_pkg::ST_IGNORED;
                end
            endcase
        end
        op.kind = kind_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            kind_reg  <= '0;
            bc_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            bc_reg    <= bc_next;
        end
    end

endmodule

// ----- rtl/lfbd_queue.sv -----
// ----------------------------------------------------------------------------
// lfbd_queue
// Two-entry queue of operations between the front and the back.
// ----------------------------------------------------------------------------
module lfbd_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lfbd_pkg::op_t  push_op,
    input  logic           pop,
    output lfbd_pkg::op_t  head,
    output logic           nempty,
    output logic           full
);

    lfbd_pkg::op_t  ent_reg [2];
    logic           wp_reg, rp_reg;
    logic [1:0]     cnt_reg;

    assign head   = ent_reg[rp_reg];
    assign nempty = (cnt_reg != 2'd0);
    assign full   = (cnt_reg == 2'd2);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wp_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ----- rtl/lfbd_back.sv -----
// ----------------------------------------------------------------------------
// lfbd_back
// Carries out store operations on the frame memory and holds the result.
// ----------------------------------------------------------------------------
module lfbd_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  lfbd_pkg::op_t  head,
    input  logic           nempty,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [2:0]     status,
    output logic [1:0]     frame_kind,
    output logic [15:0]    read_value
);

    logic [lfbd_pkg::ROW_W-1:0]  mem [lfbd_pkg::ROWS];
    logic [lfbd_pkg::ROW_W-1:0]  mem_q_reg;
    logic [lfbd_pkg::ROW_W-1:0]  acc_reg, acc_next;
    logic [lfbd_pkg::ROWS-1:0]   rv_reg, rv_next;
    logic                        out_valid_reg, hit_reg, rd_ok_reg;
    logic [2:0]                  status_reg;
    logic [1:0]                  kind_reg;
    logic [5:0]                  ch_reg;

    assign pop        = nempty && (!out_valid_reg || !out_stall);
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign frame_kind = kind_reg;
    assign read_value = (rd_ok_reg && hit_reg)
                        ? mem_q_reg[ch_reg*lfbd_pkg::WORD_BITS +: lfbd_pkg::WORD_BITS] : '0;

    always_comb
    begin
        for (int j = 0; j < lfbd_pkg::CHANNELS; j++)
        begin
            acc_next[j*lfbd_pkg::WORD_BITS +: lfbd_pkg::WORD_BITS] =
                (head.first ? '0 : acc_reg[j*lfbd_pkg::WORD_BITS +: lfbd_pkg::WORD_BITS])
                | (lfbd_pkg::WORD_BITS'(head.word[j]) << head.ibit);
        end
        rv_next = rv_reg;
        if (head.op == lfbd_pkg::OP_WRITE)
        begin
            rv_next[head.row] = 1'b1;
        end
        else if (head.op == lfbd_pkg::OP_CLEAR)
        begin
            for (int r = 0; r < lfbd_pkg::ROWS; r++)
            begin
                if (r >= int'(head.row) && r < int'(head.row) + lfbd_pkg::WORDS)
                begin
                    rv_next[r] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.op == lfbd_pkg::OP_WRITE)
        begin
            mem[head.row] <= acc_next;
            acc_reg       <= acc_next;
        end
        if (pop && head.op == lfbd_pkg::OP_READ)
        begin
            mem_q_reg <= mem[head.row];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rv_reg        <= '0;
            hit_reg       <= 1'b0;
            rd_ok_reg     <= 1'b0;
            status_reg    <= '0;
            kind_reg      <= '0;
            ch_reg        <= '0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
            rv_reg        <= rv_next;
            hit_reg       <= rv_reg[head.row];
            rd_ok_reg     <= (head.op == lfbd_pkg::OP_READ) && head.rd_ok;
            status_reg    <= head.status;
            kind_reg      <= head.kind;
            ch_reg        <= head.channel;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop && head.op == lfbd_pkg::OP_WRITE |=> rv_reg[$past(head.row)])
        else $error("written row not marked valid");

    a_value_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_value != '0 |-> status == lfbd_pkg::ST_READ)
        else $error("nonzero read value on a non-read result");

    a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> nempty && !(out_valid && out_stall))
        else $error("operation issued without room for its result");

endmodule

// ----- rtl/link_frame_bit_deinterleaver_unit.sv -----
// An accepted request waits in the two-entry queue, and its result is registered when
// it is popped. Throughput: one request per cycle while in_stall is low; the queue
// and result register set the pace, and each data word updates one 1024-bit store
// row in one write. Reset clears the phase, counters, queue and row valid bits at
// once, and loads the default patterns; the store needs no clearing pass and
// requests are taken right after reset.
// ----------------------------------------------------------------------------
// link_frame_bit_deinterleaver_unit
// Rebuilds per-channel frames from link words and reads stored words back.
// ----------------------------------------------------------------------------
module link_frame_bit_deinterleaver_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic         req_type,
    input  logic [63:0]  link_word,
    input  logic [1:0]   read_type,
    input  logic [5:0]   read_channel,
    input  logic [3:0]   read_word,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [2:0]   status,
    output logic [1:0]   frame_kind,
    output logic [15:0]  read_value,
    input  logic         wr_en,
    input  logic [1:0]   wr_index,
    input  logic [63:0]  wr_data
);

    lfbd_pkg::op_t  fop, head;
    logic           accept, pop, nempty, full;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    lfbd_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .req_type     (req_type),
        .link_word    (link_word),
        .read_type    (read_type),
        .read_channel (read_channel),
        .read_word    (read_word),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .op           (fop)
    );

    lfbd_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (accept),
        .push_op (fop),
        .pop     (pop),
        .head    (head),
        .nempty  (nempty),
        .full    (full)
    );

    lfbd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .nempty     (nempty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .frame_kind (frame_kind),
        .read_value (read_value)
    );

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Link frame bit deinterleaver testbench
// Drives link words and read-back requests with random bursts and stalls and
// compares every result with a behavioral model of the frame rebuilder.
// ----------------------------------------------------------------------------
module testbench;

    localparam int PH_HUNT = 0;
    localparam int PH_DATA = 1;
    localparam int PH_END  = 2;

    class frame_scoreboard;
        logic [63:0]       pat [4];
        int                phase;
        logic [1:0]        kind;
        int                bit_count;
        logic [15:0]       store [lfbd_pkg::FRAME_KINDS][lfbd_pkg::CHANNELS][lfbd_pkg::WORDS];
        lfbd_pkg::status_t exp_status [$];
        logic [1:0]        exp_kind [$];
        logic [15:0]       exp_value [$];
        int                errors;

        function new();
            pat[lfbd_pkg::REG_BEGIN_A] = lfbd_pkg::RST_BEGIN_A;
            pat[lfbd_pkg::REG_BEGIN_B] = lfbd_pkg::RST_BEGIN_B;
            pat[lfbd_pkg::REG_BEGIN_C] = lfbd_pkg::RST_BEGIN_C;
            pat[lfbd_pkg::REG_END] = lfbd_pkg::RST_END;
            phase = PH_HUNT;
            kind = 0;
            bit_count = 0;
            errors = 0;
            foreach (store[t, c, w])
                store[t][c][w] = '0;
        endfunction

        function void begin_frame(int k);
            for (int c = 0; c < lfbd_pkg::CHANNELS; c++)
                for (int w = 0; w < lfbd_pkg::WORDS; w++)
                    store[k][c][w] = '0;
            kind = k[1:0];
            bit_count = 0;
            phase = PH_DATA;
        endfunction

        function void note_request(logic rt, logic [63:0] lw, logic [1:0] t,
                                   logic [5:0] ch, logic [3:0] wd);
            lfbd_pkg::status_t st;
            logic [15:0] v;
            int b;
            int iw;
            int ib;
            st = lfbd_pkg::ST_IGNORED;
            v = '0;
            b = -1;
            if (rt) begin
                st = lfbd_pkg::ST_READ;
                if (t < lfbd_pkg::FRAME_KINDS && wd < lfbd_pkg::WORDS)
                    v = store[t][ch][wd];
            end
            else begin
                for (int k = lfbd_pkg::FRAME_KINDS - 1; k >= 0; k--)
                    if (lw == pat[k])
                        b = k;
                if (phase == PH_HUNT) begin
                    if (b >= 0)
                    begin
                        begin_frame(b);
                        st = lfbd_pkg::ST_BEGUN;
                    end
                end
                else if (b >= 0) begin
                    begin_frame(b);
                    st = lfbd_pkg::ST_ABORT_BEG;
                end
                else if (lw == pat[lfbd_pkg::REG_END]) begin
                    st = (phase == PH_END) ? lfbd_pkg::ST_DONE : lfbd_pkg::ST_ABORT;
                    phase = PH_HUNT;
                end
                else if (phase == PH_END) begin
                    st = lfbd_pkg::ST_ABORT;
                    phase = PH_HUNT;
                end
                else begin
                    iw = lfbd_pkg::WORDS - 1 - bit_count / lfbd_pkg::WORD_BITS;
                    ib = lfbd_pkg::WORD_BITS - 1 - bit_count % lfbd_pkg::WORD_BITS;
                    for (int j = 0; j < lfbd_pkg::CHANNELS; j++)
                        if (lw[j])
                            store[kind][j][iw][ib] = 1'b1;
                    bit_count++;
                    if (bit_count >= lfbd_pkg::FRAME_BITS)
                        phase = PH_END;
                    st = lfbd_pkg::ST_STORED;
                end
            end
            exp_status = {exp_status, st};
            exp_kind = {exp_kind, kind};
            exp_value = {exp_value, v};
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_result(logic [2:0] st, logic [1:0] k, logic [15:0] v);
            if (exp_status.size() == 0) begin
                report($sformatf("unexpected result status %0d", st));
                return;
            end
            if (st !== exp_status[0])
                report($sformatf("status %0d, want %0d", st, exp_status[0]));
            if (k !== exp_kind[0])
                report($sformatf("frame_kind %0d, want %0d", k, exp_kind[0]));
            if (v !== exp_value[0])
                report($sformatf("read_value %h, want %h", v, exp_value[0]));
            void'(exp_status.pop_front());
            void'(exp_kind.pop_front());
            void'(exp_value.pop_front());
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [63:0] link_word;
    logic [1:0]  read_type;
    logic [5:0]  read_channel;
    logic [3:0]  read_word;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [1:0]  frame_kind;
    logic [15:0] read_value;
    logic        wr_en;
    logic [1:0]  wr_index;
    logic [63:0] wr_data;

    frame_scoreboard sb;
    int          hold_off;
    int          gap_left;

    link_frame_bit_deinterleaver_unit u_top (.*);

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall)
            sb.note_request(req_type, link_word, read_type, read_channel, read_word);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(status, frame_kind, read_value);
    end

    always @(posedge clk) begin
        if (hold_off > 0) begin
            out_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end
        else
            out_stall <= ($urandom_range(0, 3) == 0) && ($urandom_range(0, 1) == 0);
    end

    function logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send(logic rt, logic [63:0] lw, logic [1:0] t, logic [5:0] ch,
                        logic [3:0] wd);
        if (gap_left == 0 && $urandom_range(0, 9) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rt;
        link_word <= lw;
        read_type <= t;
        read_channel <= ch;
        read_word <= wd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (gap_left > 0)
            gap_left--;
    endtask

    task automatic send_word(logic [63:0] lw);
        send(1'b0, lw, 2'($urandom()), 6'($urandom()), 4'($urandom()));
    endtask

    task automatic send_read(logic [1:0] t, logic [5:0] ch, logic [3:0] wd);
        send(1'b1, rand64(), t, ch, wd);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.exp_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        sb.pat[idx] = val;
        @(posedge clk);
    endtask

    task automatic send_frame(int k, int len, bit good_end);
        send_word(sb.pat[k]);
        for (int i = 0; i < len; i++)
            send_word($urandom_range(0, 7) == 0 ? 64'hffff_ffff_ffff_ffff : rand64());
        if (good_end)
            send_word(sb.pat[lfbd_pkg::REG_END]);
        else
            send_word(rand64());
        repeat (6)
            send_read(2'($urandom_range(0, 3)), 6'($urandom()),
                      4'($urandom_range(0, 15)));
    endtask

    initial begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = 1'b0;
        link_word = '0;
        read_type = '0;
        read_channel = '0;
        read_word = '0;
        out_stall = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        hold_off = 0;
        gap_left = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word('0);
        send_word('1);
        send_word(lfbd_pkg::RST_END);
        send_read(2'd3, 6'd63, 4'd15);
        send_read(2'd0, 6'd0, 4'd0);
        send_word(lfbd_pkg::RST_BEGIN_A);
        send_word('1);
        send_word(lfbd_pkg::RST_END);
        send_word(lfbd_pkg::RST_BEGIN_B);
        send_word(64'h8000_0000_0000_0001);
        send_word(lfbd_pkg::RST_BEGIN_C);
        send_read(2'd1, 6'd63, 4'd11);
        send_read(2'd1, 6'd0, 4'd12);
        send_read(2'd0, 6'd0, 4'd11);
        gap_left = 1000;
        send_frame(0, lfbd_pkg::FRAME_BITS, 1);
        gap_left = 0;
        send_read(2'd0, 6'd63, 4'd0);
        drain();

        write_reg(lfbd_pkg::REG_BEGIN_A, '0);
        write_reg(lfbd_pkg::REG_BEGIN_B, '1);
        write_reg(lfbd_pkg::REG_BEGIN_C, '1);
        write_reg(lfbd_pkg::REG_END, 64'h0000_0000_0000_0001);
        send_word('1);
        send_word(64'h1);
        send_frame(1, 3, 1);
        send_frame(0, lfbd_pkg::FRAME_BITS, 1);
        drain();

        for (int s = 0; s < 3; s++) begin
            for (int r = 0; r < 4; r++)
                write_reg(r[1:0], s == 2 ? 64'h8000_0000_0000_0000 >> r : rand64());
            fork
                begin
                    if (s == 1) begin
                        hold_off = 200;
                    end
                end
            join
            for (int f = 0; f < 1; f++) begin
                case ($urandom_range(0, 5))
                    0: send_frame($urandom_range(0, 2), $urandom_range(0, 40), 1);
                    1: send_frame($urandom_range(0, 2), lfbd_pkg::FRAME_BITS, 0);
                    2: begin
                        send_word(sb.pat[$urandom_range(0, 2)]);
                        repeat ($urandom_range(1, 10)) send_word(rand64());
                        send_word(sb.pat[$urandom_range(0, 3)]);
                    end
                    default: send_frame($urandom_range(0, 2), lfbd_pkg::FRAME_BITS, 1);
                endcase
                repeat ($urandom_range(0, 8))
                    send_read(2'($urandom_range(0, 2)), 6'($urandom()),
                              4'($urandom_range(0, 12)));
            end
            drain();
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.exp_status.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
